// ===== sv/crs_pkg.sv =====
// Shared types, widths, stage timing and arithmetic helpers of the
// chordal Catmull-Rom segment unit. No dependencies.
package crs_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int WBITS     = 30;
    localparam int WGT_W     = WBITS + 1;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;
    localparam logic [WGT_W-1:0]  W_ONE    = WGT_W'(1) << WBITS;
    localparam int                W_HALF   = 1 << (WBITS - 1);

    localparam int MAG_W     = COORD_W;
    localparam int ROOT_W    = MAG_W + 1;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 32;
    localparam int MUL_W     = MUL_A_W + MUL_B_W;
    localparam int PROD_W    = 64;
    localparam int DEN_W     = ROOT_W + 1;
    localparam int NUM_W     = 64;
    localparam int QUO_STEPS = 34;
    localparam int QUO_W     = QUO_STEPS + 1;
    localparam int TERM_W    = 34;
    localparam int SUM_W     = 40;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((64'(1) << (COORD_W - 1)) - 64'(1));
    localparam logic signed [SUM_W-1:0] SUM_MIN = ~SUM_MAX;

    // Stage timing, counted in cycles after the accepting edge.
    localparam int SQ_LAT  = SQ_STEPS + 1;
    localparam int DIV_LAT = QUO_STEPS + 2;
    localparam int K_ABS   = 1;
    localparam int K_SQ    = 2;
    localparam int K_RAD   = 3;
    localparam int K_D     = K_RAD + SQ_LAT;
    localparam int K_DS    = K_D + 1;
    localparam int K_QR    = K_DS + DIV_LAT;
    localparam int K_W1    = K_QR + 1;
    localparam int K_W2    = K_QR + 2;
    localparam int K_W3    = K_QR + 3;
    localparam int K_W4    = K_QR + 4;
    localparam int K_W5    = K_QR + 5;
    localparam int K_W6    = K_W5 + 1;
    localparam int K_R     = K_W5 + DIV_LAT;
    localparam int K_OUT   = K_R + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p3_x;
        logic signed [COORD_W-1:0] p3_y;
        logic [FRAC_W-1:0]         fraction;
    } t_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      degenerate;
    } t_result;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_sm;

    // Sign and magnitude of a - b.
    function automatic t_sm diff_sm(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        diff_sm.neg = d[COORD_W];
        diff_sm.mag = d[COORD_W] ? MAG_W'(~d + (COORD_W+1)'(1)) : d[MAG_W-1:0];
    endfunction

    function automatic logic [MUL_W-1:0] mul_u(input logic [MUL_A_W-1:0] a,
                                               input logic [MUL_B_W-1:0] b);
        mul_u = MUL_W'(a) * MUL_W'(b);
    endfunction

    // Divide by one weight unit, rounding half away from zero on a magnitude.
    function automatic logic [MUL_W:0] rnd_w(input logic [MUL_W-1:0] v);
        rnd_w = ({1'b0, v} + (MUL_W+1)'(W_HALF)) >> WBITS;
    endfunction

endpackage

// ===== sv/crs_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on crs_pkg.
module crs_sqrt (
    input  logic                         i_clk,
    input  logic [crs_pkg::RAD_W-1:0]    i_rad,
    output logic [crs_pkg::ROOT_W-1:0]   o_root
);
    import crs_pkg::*;

    logic [RAD_W-1:0]  r_rad  [SQ_STEPS+1];
    logic [ROOT_W+1:0] r_rem  [SQ_STEPS+1];
    logic [ROOT_W-1:0] r_root [SQ_STEPS+1];
    logic [ROOT_W+3:0] rem_sh [SQ_STEPS];
    logic [ROOT_W+3:0] trial  [SQ_STEPS];

    always_comb begin
        for (int g = 0; g < SQ_STEPS; g++) begin
            rem_sh[g] = {r_rem[g], r_rad[g][RAD_W-1 -: 2]};
            trial[g]  = {2'b00, r_root[g], 2'b01};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad[0]  <= i_rad;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        for (int g = 0; g < SQ_STEPS; g++) begin
            r_rad[g+1] <= r_rad[g] << 2;
            if (rem_sh[g] >= trial[g]) begin
                r_rem[g+1]  <= (ROOT_W+2)'(rem_sh[g] - trial[g]);
                r_root[g+1] <= {r_root[g][ROOT_W-2:0], 1'b1};
            end else begin
                r_rem[g+1]  <= rem_sh[g][ROOT_W+1:0];
                r_root[g+1] <= {r_root[g][ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root[SQ_STEPS];

endmodule

// ===== sv/crs_div.sv =====
// Pipelined restoring divider with round-to-nearest, one quotient bit per stage.
// Depends on crs_pkg.
module crs_div (
    input  logic                        i_clk,
    input  logic [crs_pkg::NUM_W-1:0]   i_num,
    input  logic [crs_pkg::DEN_W-1:0]   i_den,
    output logic [crs_pkg::QUO_W-1:0]   o_quo
);
    import crs_pkg::*;

    logic [DEN_W-1:0]     r_rem [QUO_STEPS+1];
    logic [QUO_STEPS-1:0] r_low [QUO_STEPS+1];
    logic [QUO_STEPS-1:0] r_quo [QUO_STEPS+1];
    logic [DEN_W-1:0]     r_den [QUO_STEPS+1];
    logic [DEN_W:0]       rem_sh [QUO_STEPS];
    logic [QUO_W-1:0]     r_out;
    logic                 round_up;

    // The quotient is known to fit, so the upper numerator bits start below the divisor.
    always_comb begin
        for (int g = 0; g < QUO_STEPS; g++) begin
            rem_sh[g] = {r_rem[g], r_low[g][QUO_STEPS-1]};
        end
        round_up = ({r_rem[QUO_STEPS], 1'b0} >= {1'b0, r_den[QUO_STEPS]});
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= DEN_W'(i_num[NUM_W-1:QUO_STEPS]);
        r_low[0] <= i_num[QUO_STEPS-1:0];
        r_quo[0] <= '0;
        r_den[0] <= i_den;
        for (int g = 0; g < QUO_STEPS; g++) begin
            r_low[g+1] <= r_low[g] << 1;
            r_den[g+1] <= r_den[g];
            if (rem_sh[g] >= {1'b0, r_den[g]}) begin
                r_rem[g+1] <= DEN_W'(rem_sh[g] - {1'b0, r_den[g]});
                r_quo[g+1] <= {r_quo[g][QUO_STEPS-2:0], 1'b1};
            end else begin
                r_rem[g+1] <= rem_sh[g][DEN_W-1:0];
                r_quo[g+1] <= {r_quo[g][QUO_STEPS-2:0], 1'b0};
            end
        end
        r_out <= QUO_W'(r_quo[QUO_STEPS]) + QUO_W'(round_up);
    end

    assign o_quo = r_out;

endmodule

// ===== sv/catmull_rom_segment_subdivide_unit.sv =====
// Top level of the chordal Catmull-Rom segment unit.
// Depends on crs_pkg, crs_sqrt and crs_div.

// A new item may be started in every clock cycle; busy is always low. The
// result of each item is shown on o_result with o_valid high for one cycle,
// and results come out in acceptance order. The path from acceptance to the
// result runs through three input stages (component magnitudes, squares and
// their sum), the 34-stage square root (input register plus one stage per
// root bit) that gives the chord lengths, one stage that registers the chords
// and their pair sums, two pipelined dividers in series (one for the chord
// ratios, one for the per-axis tangent terms), five weight stages and the
// output register. The receiver must take each result in the cycle it is
// shown; there is no way to hold it off.
module catmull_rom_segment_subdivide_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  crs_pkg::t_item    i_item,
    output logic              busy,
    output logic              o_valid,
    output crs_pkg::t_result  o_result
);
    import crs_pkg::*;

    typedef struct packed {
        t_item            pts;
        logic [WGT_W-1:0] xp;
    } t_ctx;

    typedef struct packed {
        logic [ROOT_W-1:0] d0;
        logic [ROOT_W-1:0] d1;
        logic [ROOT_W-1:0] d2;
        logic              degen;
    } t_dd;

    typedef struct packed {
        logic [COORD_W-1:0] p1_x;
        logic [COORD_W-1:0] p1_y;
        logic [TERM_W-1:0]  t1_x;
        logic [TERM_W-1:0]  t1_y;
        logic               n1_x;
        logic               n1_y;
        logic               n0_x;
        logic               n0_y;
        logic               n2_x;
        logic               n2_y;
        logic               degen;
    } t_tail;

    // Sum one axis and clamp it to the coordinate range.
    function automatic logic [COORD_W-1:0] axis_out(
        input logic [COORD_W-1:0] p1, input logic [TERM_W-1:0] t1, input logic n1,
        input logic [QUO_W-1:0] q0, input logic n0,
        input logic [QUO_W-1:0] q2, input logic n2);
        logic signed [SUM_W-1:0] s_p;
        logic signed [SUM_W-1:0] s_1;
        logic signed [SUM_W-1:0] s_0;
        logic signed [SUM_W-1:0] s_2;
        logic signed [SUM_W-1:0] s;
        s_p = SUM_W'(signed'(p1));
        s_1 = SUM_W'(t1);
        s_0 = SUM_W'(q0);
        s_2 = SUM_W'(q2);
        if (n1) s_1 = -s_1;
        if (n0) s_0 = -s_0;
        if (n2) s_2 = -s_2;
        s = s_p + s_1 + s_0 - s_2;
        priority if (s > SUM_MAX) begin
            axis_out = COORD_W'(SUM_MAX);
        end else if (s < SUM_MIN) begin
            axis_out = COORD_W'(SUM_MIN);
        end else begin
            axis_out = COORD_W'(s);
        end
    endfunction

    logic               accept;
    logic [K_OUT:1]     r_vld;
    logic [WGT_W-1:0]   n_xp;
    t_ctx               r_ctx  [K_ABS:K_W5];
    t_dd                r_dd   [K_DS:K_W5];
    t_tail              r_tail [K_W6:K_R];

    logic [COORD_W-1:0] in_p [4][2];
    logic [COORD_W-1:0] c5_p [4][2];
    t_sm                sm_a [3][2];
    t_sm                sm_5 [3][2];

    logic [MAG_W-1:0]   r_abs [3][2];
    logic [PROD_W-1:0]  r_sq  [3][2];
    logic [RAD_W-1:0]   r_rad [3];
    logic [ROOT_W-1:0]  w_root [3];
    logic [DEN_W-1:0]   r_dsum0;
    logic [DEN_W-1:0]   r_dsum2;
    logic [QUO_W-1:0]   w_qk;
    logic [QUO_W-1:0]   w_rk;

    logic [WGT_W-1:0]   yp1, yp2, yp3;
    logic [WGT_W-1:0]   r_q1, r_r1, r_q2, r_r2;
    logic [WGT_W-1:0]   r_xr, r_yq, r_xy;
    logic               r_inn_neg;
    logic [WGT_W-1:0]   r_inn_mag, r_xyy, r_xyx;
    logic               r_t_neg;
    logic [WGT_W-1:0]   r_t_mag, r_c0, r_c2;
    logic [31:0]        t_plus;
    logic [31:0]        r_kd, r_g0, r_g2;
    logic [PROD_W-1:0]  r_m0 [2];
    logic [PROD_W-1:0]  r_m1 [2];
    logic [PROD_W-1:0]  r_m2 [2];
    logic               r_n0 [2];
    logic               r_n1 [2];
    logic               r_n2 [2];
    logic [QUO_W-1:0]   w_q0 [2];
    logic [QUO_W-1:0]   w_q2 [2];
    t_result            r_res;

    // The unit never stalls, so every start is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Fractions above one are treated as one.
    assign n_xp = (i_item.fraction > FRAC_ONE) ? W_ONE
                : {i_item.fraction, {(WBITS-FRAC_BITS){1'b0}}};

    always_comb begin
        in_p[0][0] = i_item.p0_x;           in_p[0][1] = i_item.p0_y;
        in_p[1][0] = i_item.p1_x;           in_p[1][1] = i_item.p1_y;
        in_p[2][0] = i_item.p2_x;           in_p[2][1] = i_item.p2_y;
        in_p[3][0] = i_item.p3_x;           in_p[3][1] = i_item.p3_y;
        c5_p[0][0] = r_ctx[K_W4].pts.p0_x;  c5_p[0][1] = r_ctx[K_W4].pts.p0_y;
        c5_p[1][0] = r_ctx[K_W4].pts.p1_x;  c5_p[1][1] = r_ctx[K_W4].pts.p1_y;
        c5_p[2][0] = r_ctx[K_W4].pts.p2_x;  c5_p[2][1] = r_ctx[K_W4].pts.p2_y;
        c5_p[3][0] = r_ctx[K_W4].pts.p3_x;  c5_p[3][1] = r_ctx[K_W4].pts.p3_y;
        for (int c = 0; c < 3; c++) begin
            for (int a = 0; a < 2; a++) begin
                sm_a[c][a] = diff_sm(in_p[c+1][a], in_p[c][a]);
                sm_5[c][a] = diff_sm(c5_p[c+1][a], c5_p[c][a]);
            end
        end
        yp1    = W_ONE - r_ctx[K_QR].xp;
        yp2    = W_ONE - r_ctx[K_W1].xp;
        yp3    = W_ONE - r_ctx[K_W2].xp;
        t_plus = r_t_neg ? (32'(W_ONE) - 32'(r_t_mag)) : (32'(W_ONE) + 32'(r_t_mag));
    end

    // Valid bits travel alongside the data; reset empties the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[K_OUT-1:1], accept};
        end
    end

    // Item context and chord data follow their item down the pipeline.
    always_ff @(posedge i_clk) begin
        r_ctx[K_ABS] <= '{pts: i_item, xp: n_xp};
        for (int k = K_ABS + 1; k <= K_W5; k++) begin
            r_ctx[k] <= r_ctx[k-1];
        end
        r_dd[K_DS].d0    <= w_root[0];
        r_dd[K_DS].d1    <= w_root[1];
        r_dd[K_DS].d2    <= w_root[2];
        r_dd[K_DS].degen <= (w_root[0] == '0) || (w_root[1] == '0) || (w_root[2] == '0);
        for (int k = K_DS + 1; k <= K_W5; k++) begin
            r_dd[k] <= r_dd[k-1];
        end
    end

    // Chord lengths: component magnitudes, squares, sum, then the root.
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            for (int a = 0; a < 2; a++) begin
                r_abs[c][a] <= sm_a[c][a].mag;
                r_sq[c][a]  <= PROD_W'(mul_u(MUL_A_W'(r_abs[c][a]), r_abs[c][a]));
            end
            r_rad[c] <= RAD_W'(r_sq[c][0]) + RAD_W'(r_sq[c][1]);
        end
        r_dsum0 <= DEN_W'(w_root[0]) + DEN_W'(w_root[1]);
        r_dsum2 <= DEN_W'(w_root[1]) + DEN_W'(w_root[2]);
    end

    for (genvar c = 0; c < 3; c++) begin : g_chord
        crs_sqrt u_sqrt (
            .i_clk  (i_clk),
            .i_rad  (r_rad[c]),
            .o_root (w_root[c])
        );
    end

    // Chord ratios q = d1 / (d0 + d1) and r = d1 / (d1 + d2) in weight units.
    crs_div u_div_q (
        .i_clk (i_clk),
        .i_num (NUM_W'({r_dd[K_DS].d1, {WBITS{1'b0}}})),
        .i_den (r_dsum0),
        .o_quo (w_qk)
    );

    crs_div u_div_r (
        .i_clk (i_clk),
        .i_num (NUM_W'({r_dd[K_DS].d1, {WBITS{1'b0}}})),
        .i_den (r_dsum2),
        .o_quo (w_rk)
    );

    // Blending weights, one multiplication per stage and operand.
    always_ff @(posedge i_clk) begin
        r_q1 <= w_qk[WGT_W-1:0];
        r_r1 <= w_rk[WGT_W-1:0];
        r_xr <= WGT_W'(rnd_w(mul_u(MUL_A_W'(r_ctx[K_QR].xp), MUL_B_W'(w_rk[WGT_W-1:0]))));
        r_yq <= WGT_W'(rnd_w(mul_u(MUL_A_W'(yp1), MUL_B_W'(w_qk[WGT_W-1:0]))));
        r_xy <= WGT_W'(rnd_w(mul_u(MUL_A_W'(r_ctx[K_QR].xp), MUL_B_W'(yp1))));

        r_q2      <= r_q1;
        r_r2      <= r_r1;
        r_inn_neg <= (r_yq > r_xr);
        r_inn_mag <= (r_yq > r_xr) ? (r_yq - r_xr) : (r_xr - r_yq);
        r_xyy     <= WGT_W'(rnd_w(mul_u(MUL_A_W'(r_xy), MUL_B_W'(yp2))));
        r_xyx     <= WGT_W'(rnd_w(mul_u(MUL_A_W'(r_xy), MUL_B_W'(r_ctx[K_W1].xp))));

        r_t_neg <= r_inn_neg;
        r_t_mag <= WGT_W'(rnd_w(mul_u(MUL_A_W'(yp3), MUL_B_W'(r_inn_mag))));
        r_c0    <= WGT_W'(rnd_w(mul_u(MUL_A_W'(r_xyy), MUL_B_W'(r_q2))));
        r_c2    <= WGT_W'(rnd_w(mul_u(MUL_A_W'(r_xyx), MUL_B_W'(r_r2))));

        r_kd <= 32'(rnd_w(mul_u(MUL_A_W'(r_ctx[K_W3].xp), t_plus)));
        r_g0 <= 32'(rnd_w(mul_u(r_dd[K_W3].d1, MUL_B_W'(r_c0))));
        r_g2 <= 32'(rnd_w(mul_u(r_dd[K_W3].d1, MUL_B_W'(r_c2))));

        for (int a = 0; a < 2; a++) begin
            r_m1[a] <= PROD_W'(mul_u(MUL_A_W'(sm_5[1][a].mag), r_kd));
            r_m0[a] <= PROD_W'(mul_u(MUL_A_W'(sm_5[0][a].mag), r_g0));
            r_m2[a] <= PROD_W'(mul_u(MUL_A_W'(sm_5[2][a].mag), r_g2));
            r_n1[a] <= sm_5[1][a].neg;
            r_n0[a] <= sm_5[0][a].neg;
            r_n2[a] <= sm_5[2][a].neg;
        end

        r_tail[K_W6].p1_x  <= r_ctx[K_W5].pts.p1_x;
        r_tail[K_W6].p1_y  <= r_ctx[K_W5].pts.p1_y;
        r_tail[K_W6].t1_x  <= TERM_W'(rnd_w(MUL_W'(r_m1[0])));
        r_tail[K_W6].t1_y  <= TERM_W'(rnd_w(MUL_W'(r_m1[1])));
        r_tail[K_W6].n1_x  <= r_n1[0];
        r_tail[K_W6].n1_y  <= r_n1[1];
        r_tail[K_W6].n0_x  <= r_n0[0];
        r_tail[K_W6].n0_y  <= r_n0[1];
        r_tail[K_W6].n2_x  <= r_n2[0];
        r_tail[K_W6].n2_y  <= r_n2[1];
        r_tail[K_W6].degen <= r_dd[K_W5].degen;
        for (int k = K_W6 + 1; k <= K_R; k++) begin
            r_tail[k] <= r_tail[k-1];
        end
    end

    // Tangent terms divided by the outer chord lengths, per axis.
    for (genvar a = 0; a < 2; a++) begin : g_axis
        crs_div u_div_0 (
            .i_clk (i_clk),
            .i_num (r_m0[a]),
            .i_den (DEN_W'(r_dd[K_W5].d0)),
            .o_quo (w_q0[a])
        );
        crs_div u_div_2 (
            .i_clk (i_clk),
            .i_num (r_m2[a]),
            .i_den (DEN_W'(r_dd[K_W5].d2)),
            .o_quo (w_q2[a])
        );
    end

    // A zero-length chord forces the point to the origin.
    always_ff @(posedge i_clk) begin
        r_res.degenerate <= r_tail[K_R].degen;
        if (r_tail[K_R].degen) begin
            r_res.out_x <= '0;
            r_res.out_y <= '0;
        end else begin
            r_res.out_x <= axis_out(r_tail[K_R].p1_x, r_tail[K_R].t1_x, r_tail[K_R].n1_x,
                                    w_q0[0], r_tail[K_R].n0_x, w_q2[0], r_tail[K_R].n2_x);
            r_res.out_y <= axis_out(r_tail[K_R].p1_y, r_tail[K_R].t1_y, r_tail[K_R].n1_y,
                                    w_q0[1], r_tail[K_R].n0_y, w_q2[1], r_tail[K_R].n2_y);
        end
    end

    assign o_valid  = r_vld[K_OUT];
    assign o_result = r_res;

endmodule

// ===== sv/crs_checker.sv =====
// Port-level checks for the Catmull-Rom segment unit, bound to its top level.
// Depends on crs_pkg and catmull_rom_segment_subdivide_unit.
module crs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input crs_pkg::t_item    i_item,
    input logic              busy,
    input logic              o_valid,
    input crs_pkg::t_result  o_result
);
    import crs_pkg::*;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("unit reported busy");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, K_OUT))
        else $error("result without an item started at the fixed latency");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.degenerate) |-> (o_result.out_x == 0 && o_result.out_y == 0))
        else $error("degenerate result with a nonzero point");

    a_zero_chord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.p1_x == i_item.p2_x && i_item.p1_y == i_item.p2_y)
        |-> ##K_OUT (o_valid && o_result.degenerate))
        else $error("coincident segment ends not flagged degenerate");

endmodule

bind catmull_rom_segment_subdivide_unit crs_checker u_crs_checker (.*);

// ===== tb/sv/catmull_rom_segment_subdivide_unit_tb.sv =====
// Self-checking testbench of the chordal Catmull-Rom segment unit.
// Depends on crs_pkg and catmull_rom_segment_subdivide_unit.
`timescale 1ns / 100ps

module catmull_rom_segment_subdivide_unit_tb;
    import crs_pkg::*;

    localparam int  RANDOM_ITEMS = 1950;
    localparam int  LATENCY      = 116;
    localparam longint CYCLE_LIMIT = 200000;
    localparam logic [63:0] WONE64 = 64'd1 << WBITS;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_item   i_item = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    int      failures = 0;
    longint  cycles = 0;
    t_result pending_points[$];

    catmull_rom_segment_subdivide_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item),
        .busy(busy), .o_valid(o_valid), .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    // Integer square root, rounded down, of a sum of two squares.
    function automatic logic [63:0] chord_length(input longint dx, input longint dy);
        logic [127:0] n;
        logic [127:0] c;
        logic [63:0] root;
        logic [63:0] ax;
        logic [63:0] ay;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        n = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            c = 128'(root | (64'd1 << b));
            if (c * c <= n) root = c[63:0];
        end
        return root;
    endfunction

    // a * b / c rounded to nearest, ties away from zero, clamped to 63 bits.
    function automatic longint scaled_ratio(input longint a, input longint b,
                                            input logic [63:0] c);
        logic neg;
        logic [127:0] n;
        logic [127:0] quo;
        logic [127:0] rem;
        neg = (a < 0) != (b < 0);
        if (c == 0) return 0;
        n = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        quo = n / c;
        rem = n % c;
        if (rem >= 128'(c) - rem) quo++;
        if (quo > 128'h7FFF_FFFF_FFFF_FFFF) quo = 128'h7FFF_FFFF_FFFF_FFFF;
        return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    function automatic logic signed [COORD_W-1:0] saturate(input longint v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return v[COORD_W-1:0];
    endfunction

    // Point on the segment from p1 to p2 at the given fraction.
    function automatic t_result segment_point(input t_item it);
        t_result res;
        longint px[4];
        longint py[4];
        logic [63:0] d0, d1, d2;
        longint xp, yp, q, r, inner, t, kd, xy, g0, g2;
        logic [FRAC_W-1:0] f;
        px = '{longint'(it.p0_x), longint'(it.p1_x), longint'(it.p2_x), longint'(it.p3_x)};
        py = '{longint'(it.p0_y), longint'(it.p1_y), longint'(it.p2_y), longint'(it.p3_y)};
        f = it.fraction > FRAC_ONE ? FRAC_ONE : it.fraction;
        d0 = chord_length(px[1] - px[0], py[1] - py[0]);
        d1 = chord_length(px[2] - px[1], py[2] - py[1]);
        d2 = chord_length(px[3] - px[2], py[3] - py[2]);
        res = '0;
        if (d0 == 0 || d1 == 0 || d2 == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        xp = longint'(f) <<< (WBITS - FRAC_BITS);
        yp = longint'(WONE64) - xp;
        q = scaled_ratio(d1, WONE64, d0 + d1);
        r = scaled_ratio(d1, WONE64, d1 + d2);
        inner = scaled_ratio(xp, r, WONE64) - scaled_ratio(yp, q, WONE64);
        t = scaled_ratio(yp, inner, WONE64);
        kd = scaled_ratio(xp, longint'(WONE64) + t, WONE64);
        xy = scaled_ratio(xp, yp, WONE64);
        g0 = scaled_ratio(d1, scaled_ratio(scaled_ratio(xy, yp, WONE64), q, WONE64), WONE64);
        g2 = scaled_ratio(d1, scaled_ratio(scaled_ratio(xy, xp, WONE64), r, WONE64), WONE64);
        res.out_x = saturate(px[1] + scaled_ratio(px[2] - px[1], kd, WONE64)
                             + scaled_ratio(px[1] - px[0], g0, d0)
                             - scaled_ratio(px[3] - px[2], g2, d2));
        res.out_y = saturate(py[1] + scaled_ratio(py[2] - py[1], kd, WONE64)
                             + scaled_ratio(py[1] - py[0], g0, d0)
                             - scaled_ratio(py[3] - py[2], g2, d2));
        return res;
    endfunction

    // Each point shown by the unit is compared with the oldest prediction.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (pending_points.size() == 0) begin
                $error("point with no prediction waiting");
                failures++;
            end else begin
                t_result exp_pt;
                exp_pt = pending_points.pop_front();
                if (o_result.out_x !== exp_pt.out_x) begin
                    $error("out_x expected %0d actual %0d", exp_pt.out_x, o_result.out_x);
                    failures++;
                end
                if (o_result.out_y !== exp_pt.out_y) begin
                    $error("out_y expected %0d actual %0d", exp_pt.out_y, o_result.out_y);
                    failures++;
                end
                if (o_result.degenerate !== exp_pt.degenerate) begin
                    $error("degenerate expected %0b actual %0b",
                           exp_pt.degenerate, o_result.degenerate);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Holds start high at the falling edge, waits for the accepting edge, then
    // lowers it only if a gap follows; back-to-back items keep start high.
    task automatic send_point(input t_item it, input logic known, input t_result fixed,
                              input int gap);
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        pending_points.push_back(known ? fixed : segment_point(it));
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord(input int spread);
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed(32'($urandom_range(spread))) - spread / 2;
            2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed(32'($urandom_range(32'h00FF_FFFF))) - 32'sh0080_0000;
        endcase
    endfunction

    typedef struct {
        t_item   it;
        logic    known;
        t_result fixed;
    } t_row;

    initial begin
        t_row rows[$];
        t_row row;
        t_item it;
        int idle_mode;
        int quiet;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: a predicted point has known cleared.
        row.known = 1'b0; row.fixed = '0;
        // Straight line at fraction zero, one half and one.
        row.it = '{32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh20000, 32'sh0,
                   32'sh30000, 32'sh0, 17'd0};
        rows.push_back(row);
        row.it.fraction = 17'h08000; rows.push_back(row);
        row.it.fraction = FRAC_ONE; rows.push_back(row);
        // Fraction above one acts as one.
        row.it.fraction = 17'h1FFFF; rows.push_back(row);
        row.it.fraction = 17'h10001; rows.push_back(row);
        // Extreme corners, so the sums overflow and saturate.
        row.it = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                   32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                   17'h08000};
        rows.push_back(row);
        row.it = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                   32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                   17'h04000};
        rows.push_back(row);
        row.it.fraction = 17'h1C000; rows.push_back(row);
        // Tight chords of one unit.
        row.it = '{32'sh0, 32'sh0, 32'sh1, 32'sh0, 32'sh1, 32'sh1, 32'sh0, 32'sh1, 17'h0AAAA};
        rows.push_back(row);
        // Zero chords: a repeated point gives a degenerate zero point.
        row.known = 1'b1; row.fixed = '{32'sh0, 32'sh0, 1'b1};
        row.it = '{32'sh5, 32'sh5, 32'sh5, 32'sh5, 32'sh9, 32'sh1, 32'sh3, 32'sh3, 17'h08000};
        rows.push_back(row);
        row.it = '{32'sh0, 32'sh0, 32'sh7, 32'sh7, 32'sh7, 32'sh7, 32'sh3, 32'sh3, 17'h08000};
        rows.push_back(row);
        row.it = '{32'sh0, 32'sh0, 32'sh7, 32'sh7, 32'sh8, 32'sh7, 32'sh8, 32'sh7, FRAC_ONE};
        rows.push_back(row);
        row.it = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   17'h1FFFF};
        rows.push_back(row);
        foreach (rows[i]) send_point(rows[i].it, rows[i].known, rows[i].fixed,
                                     $urandom_range(1) ? 0 : $urandom_range(17));

        // Random part: stretches of back-to-back items alternate with gaps.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 200 == 0) idle_mode = $urandom_range(2);
            it.p0_x = rand_coord(1 << $urandom_range(30));
            it.p0_y = rand_coord(1 << $urandom_range(30));
            it.p1_x = rand_coord(1 << $urandom_range(30));
            it.p1_y = rand_coord(1 << $urandom_range(30));
            it.p2_x = rand_coord(1 << $urandom_range(30));
            it.p2_y = rand_coord(1 << $urandom_range(30));
            it.p3_x = rand_coord(1 << $urandom_range(30));
            it.p3_y = rand_coord(1 << $urandom_range(30));
            if ($urandom_range(15) == 0) it.p2_x = it.p1_x;
            if ($urandom_range(15) == 0) it.p2_y = it.p1_y;
            it.fraction = $urandom_range(7) == 0 ? 17'($urandom) : 17'($urandom_range(65536));
            send_point(it, 1'b0, '0, idle_mode == 0 ? 0 : $urandom_range(17));
        end
        @(negedge i_clk);
        start <= 1'b0;

        quiet = 0;
        while (pending_points.size() != 0 && quiet < 4 * LATENCY) begin
            @(posedge i_clk);
            quiet++;
        end
        repeat (LATENCY / 4) @(posedge i_clk);
        if (failures == 0 && pending_points.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
